>>> src/mipmap_pyramid_box_downsampler_unit_assert.svh
// Assertion macros for the mipmap box downsampler.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MIPMAP_PYRAMID_BOX_DOWNSAMPLER_UNIT_ASSERT_SVH
`define MIPMAP_PYRAMID_BOX_DOWNSAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define MMBOX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MMBOX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mmbox_pkg.sv
// Shared types and constants for the mipmap box downsampler.
// No dependencies.
package mmbox_pkg;
   localparam int LEVEL_W = 4;
   localparam int ROW_W   = 12;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
      logic [8:0] alpha;
   } pair_type;

   typedef struct packed {
      logic      valid;
      pixel_type px;
   } queue_head_type;
endpackage

>>> src/mmbox_front.sv
// Input front end: two-word queue of source pixels.
// Depends on mmbox_pkg.
module mmbox_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mmbox_pkg::pixel_type    req_px,
   output mmbox_pkg::queue_head_type head,
   input  logic                    pop
);
   import mmbox_pkg::*;

   pixel_type  entry_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, do_pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.px    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_px;
      end
   end
endmodule

>>> src/mmbox_back.sv
// Cascade engine: emits the source copy, then walks the levels one at a time
// using per-level counters, left-pixel holds and the pair-sum line memory.
// Depends on mmbox_pkg and the assertion macro header.
module mmbox_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_LEVELS = 10,
   parameter int CW         = $clog2(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [CW:0]                   eff_width,
   input  logic [mmbox_pkg::ROW_W-1:0]   eff_height,
   input  logic [mmbox_pkg::LEVEL_W-1:0] num_levels,
   input  mmbox_pkg::queue_head_type     head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mmbox_pkg::LEVEL_W-1:0] rsp_level,
   output logic [CW-1:0]                 rsp_col,
   output logic [mmbox_pkg::ROW_W-1:0]   rsp_row,
   output mmbox_pkg::pixel_type          rsp_px,
   output logic                          rsp_last
);
   import mmbox_pkg::*;

   localparam int LIW = $clog2(MAX_LEVELS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EMIT = 2'd1;
   localparam logic [1:0] ST_AVG  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [LEVEL_W-1:0] lvl_ff;
   logic [CW-1:0]      pc_ff;
   logic [ROW_W-1:0]   pr_ff;
   pixel_type          px_ff;
   pair_type           pair_ff;
   pair_type           rd_data_ff;
   logic [CW-1:0]      col_cnt_ff [0:MAX_LEVELS];
   logic [ROW_W-1:0]   row_cnt_ff [0:MAX_LEVELS];
   pixel_type          pend_ff    [0:MAX_LEVELS];
   pair_type           line_mem   [0:MAX_WIDTH-1];

   logic                out_valid_ff;
   logic [LEVEL_W-1:0]  out_lvl_ff;
   logic [CW-1:0]       out_col_ff;
   logic [ROW_W-1:0]    out_row_ff;
   pixel_type           out_px_ff;
   logic                out_last_ff;

   logic [LEVEL_W-1:0] k1;
   logic [LIW-1:0]     cur_i, nxt_i;
   logic [CW:0]        wk1, wcur;
   logic [ROW_W-1:0]   hk1, hcur;
   logic               in_range, idx_ok, cont, out_free, emit_go;
   logic               pend_wr, mem_wr, mem_rd;
   logic [CW+1:0]      idx_full;
   logic [CW-1:0]      idx;
   pixel_type          pend_rd;
   pair_type           pair;
   pixel_type          avg;
   logic [9:0]         s_r, s_g, s_b, s_a;

   assign k1    = lvl_ff + LEVEL_W'(1);
   assign cur_i = lvl_ff[LIW-1:0];
   assign nxt_i = k1[LIW-1:0];
   assign wk1   = eff_width >> k1;
   assign hk1   = eff_height >> k1;
   assign wcur  = eff_width >> lvl_ff;
   assign hcur  = eff_height >> lvl_ff;

   assign in_range = (lvl_ff < num_levels)
                  && ({2'b0, pc_ff} < {wk1, 1'b0})
                  && ({1'b0, pr_ff} < {hk1, 1'b0});
   assign idx_full = (CW+2)'(MAX_WIDTH) - ((CW+2)'(MAX_WIDTH) >> lvl_ff)
                   + (CW+2)'(pc_ff >> 1);
   assign idx_ok   = idx_full < (CW+2)'(MAX_WIDTH);
   assign idx      = idx_full[CW-1:0];
   assign pend_rd  = pend_ff[nxt_i];
   assign pair.red   = {1'b0, pend_rd.red}   + {1'b0, px_ff.red};
   assign pair.green = {1'b0, pend_rd.green} + {1'b0, px_ff.green};
   assign pair.blue  = {1'b0, pend_rd.blue}  + {1'b0, px_ff.blue};
   assign pair.alpha = {1'b0, pend_rd.alpha} + {1'b0, px_ff.alpha};
   assign cont     = in_range && pc_ff[0] && idx_ok && pr_ff[0];

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit_go  = (state_ff == ST_EMIT) && out_free;
   assign pend_wr  = emit_go && in_range && !pc_ff[0];
   assign mem_wr   = emit_go && in_range && pc_ff[0] && idx_ok && !pr_ff[0];
   assign mem_rd   = emit_go && cont;
   assign pop      = (state_ff == ST_IDLE) && head.valid;

   assign s_r = 10'(rd_data_ff.red)   + 10'(pair_ff.red)   + 10'd2;
   assign s_g = 10'(rd_data_ff.green) + 10'(pair_ff.green) + 10'd2;
   assign s_b = 10'(rd_data_ff.blue)  + 10'(pair_ff.blue)  + 10'd2;
   assign s_a = 10'(rd_data_ff.alpha) + 10'(pair_ff.alpha) + 10'd2;
   assign avg = '{red: s_r[9:2], green: s_g[9:2], blue: s_b[9:2], alpha: s_a[9:2]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (head.valid) state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = cont ? ST_AVG : ST_IDLE;
         ST_AVG:  state_in = ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         px_ff  <= head.px;
         lvl_ff <= '0;
         pc_ff  <= col_cnt_ff[0];
         pr_ff  <= row_cnt_ff[0];
      end else if (state_ff == ST_AVG) begin
         px_ff  <= avg;
         lvl_ff <= k1;
         pc_ff  <= col_cnt_ff[nxt_i];
         pr_ff  <= row_cnt_ff[nxt_i];
      end
      if (mem_rd) begin
         pair_ff <= pair;
      end
      if (pend_wr) begin
         pend_ff[nxt_i] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i <= MAX_LEVELS; i++) begin
            col_cnt_ff[i] <= '0;
            row_cnt_ff[i] <= '0;
         end
      end else if (emit_go) begin
         if ({1'b0, col_cnt_ff[cur_i]} + (CW+1)'(1) >= wcur) begin
            col_cnt_ff[cur_i] <= '0;
            if ({1'b0, row_cnt_ff[cur_i]} + (ROW_W+1)'(1) >= {1'b0, hcur}) begin
               row_cnt_ff[cur_i] <= '0;
            end else begin
               row_cnt_ff[cur_i] <= row_cnt_ff[cur_i] + ROW_W'(1);
            end
         end else begin
            col_cnt_ff[cur_i] <= col_cnt_ff[cur_i] + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[idx] <= pair;
      end
      if (mem_rd) begin
         rd_data_ff <= line_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= emit_go;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         out_lvl_ff  <= lvl_ff;
         out_col_ff  <= pc_ff;
         out_row_ff  <= pr_ff;
         out_px_ff   <= px_ff;
         out_last_ff <= !cont;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_level = out_lvl_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_px    = out_px_ff;
   assign rsp_last  = out_last_ff;

`include "mipmap_pyramid_box_downsampler_unit_assert.svh"
   `MMBOX_ASSERT_NEXT(a_read_then_avg, mem_rd, state_ff == ST_AVG, "line read not followed by average")
   `MMBOX_ASSERT_NOW(a_no_rw_clash, mem_wr, !mem_rd, "line memory read and write together")
   `MMBOX_ASSERT_NOW(a_lvl_cap, state_ff == ST_EMIT, lvl_ff <= LEVEL_W'(MAX_LEVELS), "level past cap")
   `MMBOX_ASSERT_NOW(a_pop_idle, pop, state_ff == ST_IDLE, "pixel taken while busy")
endmodule

>>> src/mipmap_pyramid_box_downsampler_unit.sv
// Streaming 2x2 box-filter mipmap builder: each RGBA8 source pixel is passed
// through as level 0 and cascades down the pyramid, one level at a time.
// The engine takes no new pixel until the last has finished its cascade;
// each extra level adds an averaging state after the registered read of the
// pair-sum line memory. A two-word queue decouples input from the engine.
// Writes to the width or height register restart the frame. Depends on
// mmbox_pkg, mmbox_front, mmbox_back.
module mipmap_pyramid_box_downsampler_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_LEVELS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mmbox_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mmbox_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_red,
   input  logic [7:0]                       req_green,
   input  logic [7:0]                       req_blue,
   input  logic [7:0]                       req_alpha,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mmbox_pkg::LEVEL_W-1:0]    rsp_level,
   output logic [$clog2(MAX_WIDTH)-1:0]     rsp_col,
   output logic [mmbox_pkg::ROW_W-1:0]      rsp_row,
   output logic [7:0]                       rsp_out_red,
   output logic [7:0]                       rsp_out_green,
   output logic [7:0]                       rsp_out_blue,
   output logic [7:0]                       rsp_out_alpha,
   output logic                             rsp_last_of_run
);
   import mmbox_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [10:0]        width_ff;
   logic [ROW_W-1:0]   height_ff;
   logic               restart;
   logic [CW:0]        eff_width;
   logic [ROW_W-1:0]   eff_height;
   logic [ROW_W-1:0]   min_wh;
   logic [LEVEL_W-1:0] log_m, num_levels;
   pixel_type          req_px, rsp_px;
   queue_head_type     head;
   logic               pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 12'd1024;
      end else if (csr_we) begin
         if (csr_index == CSR_IMAGE_WIDTH) width_ff <= csr_wdata[10:0];
         if (csr_index == CSR_IMAGE_HEIGHT) height_ff <= csr_wdata;
      end
   end

   assign restart = csr_we && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   always_comb begin
      priority if (width_ff == 11'd0) eff_width = (CW+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH) eff_width = (CW+1)'(MAX_WIDTH);
      else eff_width = (CW+1)'(width_ff);
      eff_height = (height_ff == '0) ? ROW_W'(1) : height_ff;
      min_wh = (32'(eff_width) < 32'(eff_height)) ? ROW_W'(eff_width) : eff_height;
      log_m = '0;
      for (int b = 1; b < ROW_W; b++) begin
         if (min_wh[b]) log_m = LEVEL_W'(b);
      end
      num_levels = (32'(log_m) > MAX_LEVELS) ? LEVEL_W'(MAX_LEVELS) : log_m;
   end

   assign req_px = '{red: req_red, green: req_green, blue: req_blue, alpha: req_alpha};

   mmbox_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_px    (req_px),
      .head      (head),
      .pop       (pop)
   );

   mmbox_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_LEVELS (MAX_LEVELS),
      .CW         (CW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .num_levels (num_levels),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_level  (rsp_level),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_px     (rsp_px),
      .rsp_last   (rsp_last_of_run)
   );

   assign rsp_out_red   = rsp_px.red;
   assign rsp_out_green = rsp_px.green;
   assign rsp_out_blue  = rsp_px.blue;
   assign rsp_out_alpha = rsp_px.alpha;
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mipmap_pyramid_box_downsampler_unit: random RGBA words
// over several image sizes, each result checked against an in-bench pyramid predictor.
// Depends on mmbox_pkg and the unit under test.
module tb_top;
   import mmbox_pkg::*;

   localparam int MAXW = 1024;
   localparam int MAXL = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd2;

   typedef struct {
      logic [3:0]  level;
      logic [9:0]  col;
      logic [11:0] row;
      pixel_type   px;
      logic        last;
   } mip_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_red = '0, req_green = '0, req_blue = '0, req_alpha = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_level;
   logic [9:0] rsp_col;
   logic [11:0] rsp_row;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic rsp_last_of_run;

   mipmap_pyramid_box_downsampler_unit u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [10:0] width_reg = 11'd1024;
   logic [11:0] height_reg = 12'd1024;
   int unsigned col_cnt[0:MAXL];
   int unsigned row_cnt[0:MAXL];
   pixel_type pend_px[0:MAXL];
   pair_type line_sum[0:MAXW-1];

   mip_word_type mip_q[$];
   int fails = 0;

   task automatic report(input string what);
      fails++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic void bump(input int k, input int unsigned w, input int unsigned h);
      col_cnt[k]++;
      if (col_cnt[k] >= w) begin
         col_cnt[k] = 0;
         row_cnt[k]++;
         if (row_cnt[k] >= h) row_cnt[k] = 0;
      end
   endfunction

   function automatic void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] v);
      if (idx == CSR_IMAGE_WIDTH || idx == CSR_IMAGE_HEIGHT) begin
         if (idx == CSR_IMAGE_WIDTH) width_reg = v[10:0];
         else height_reg = v;
         for (int k = 0; k <= MAXL; k++) begin
            col_cnt[k] = 0;
            row_cnt[k] = 0;
         end
      end
   endfunction

   function automatic int build_pyramid(input pixel_type src, output mip_word_type res[0:MAXL]);
      int unsigned w, h, m, wk, hk, idx, pc, pr, oc, orow, s;
      int nlev, n;
      pixel_type px;
      pair_type pr_sum;
      w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      m = (w < h) ? w : h;
      nlev = 0;
      while (m >= 2 && nlev < MAXL) begin
         m >>= 1;
         nlev++;
      end
      px = src;
      pc = col_cnt[0];
      pr = row_cnt[0];
      res[0] = '{4'd0, pc[9:0], pr[11:0], px, 1'b0};
      n = 1;
      bump(0, w, h);
      for (int k = 1; k <= nlev; k++) begin
         wk = w >> k;
         hk = h >> k;
         if (pc >= 2 * wk || pr >= 2 * hk) break;
         if (!pc[0]) begin
            pend_px[k] = px;
            break;
         end
         pr_sum.red   = pend_px[k].red + px.red;
         pr_sum.green = pend_px[k].green + px.green;
         pr_sum.blue  = pend_px[k].blue + px.blue;
         pr_sum.alpha = pend_px[k].alpha + px.alpha;
         idx = MAXW - (MAXW >> (k - 1)) + (pc >> 1);
         if (idx >= MAXW) break;
         if (!pr[0]) begin
            line_sum[idx] = pr_sum;
            break;
         end
         s = line_sum[idx].red + pr_sum.red + 2;     px.red   = s[9:2];
         s = line_sum[idx].green + pr_sum.green + 2; px.green = s[9:2];
         s = line_sum[idx].blue + pr_sum.blue + 2;   px.blue  = s[9:2];
         s = line_sum[idx].alpha + pr_sum.alpha + 2; px.alpha = s[9:2];
         oc = col_cnt[k];
         orow = row_cnt[k];
         res[n] = '{k[3:0], oc[9:0], orow[11:0], px, 1'b0};
         n++;
         bump(k, wk, hk);
         pc = oc;
         pr = orow;
      end
      res[n-1].last = 1'b1;
      return n;
   endfunction

   // result checker
   always @(posedge clock) begin
      mip_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mip_q.size() == 0) begin
            report("result word with nothing expected");
         end else begin
            e = mip_q.pop_front();
            if (rsp_level !== e.level)
               report($sformatf("level %0d, expected %0d", rsp_level, e.level));
            if (rsp_col !== e.col)
               report($sformatf("col %0d, expected %0d", rsp_col, e.col));
            if (rsp_row !== e.row)
               report($sformatf("row %0d, expected %0d", rsp_row, e.row));
            if (rsp_out_red !== e.px.red)
               report($sformatf("red %0h, expected %0h", rsp_out_red, e.px.red));
            if (rsp_out_green !== e.px.green)
               report($sformatf("green %0h, expected %0h", rsp_out_green, e.px.green));
            if (rsp_out_blue !== e.px.blue)
               report($sformatf("blue %0h, expected %0h", rsp_out_blue, e.px.blue));
            if (rsp_out_alpha !== e.px.alpha)
               report($sformatf("alpha %0h, expected %0h", rsp_out_alpha, e.px.alpha));
            if (rsp_last_of_run !== e.last)
               report($sformatf("last_of_run %0b, expected %0b", rsp_last_of_run, e.last));
         end
      end
   end

   // receiver stall pattern: free runs, light and heavy stretches
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   int burst_left = 0;

   task automatic send_word(input pixel_type p, input bit typed, input mip_word_type tw);
      mip_word_type res[0:MAXL];
      int n, gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      {req_red, req_green, req_blue, req_alpha} <= p;
      do @(posedge clock); while (req_stall);
      n = build_pyramid(p, res);
      if (typed) mip_q.push_back(tw);
      else for (int i = 0; i < n; i++) mip_q.push_back(res[i]);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      set_reg(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic pixel_type rand_px();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // directed rows after reset: 1024 wide, top row, each word gives one level-0 result
   pixel_type dir_px[20] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hFF00_FF00, 32'h00FF_00FF, 32'h0102_0408, 32'h1020_4080, 32'hFEFD_FBF7,
      32'hEFDF_BF7F, 32'h8000_0001, 32'h7FFF_FFFE, 32'hFF00_0000, 32'h00FF_0000,
      32'h0000_FF00, 32'h0000_00FF, 32'h0101_0101, 32'hFEFE_FEFE, 32'h8080_8080,
      32'h7F7F_7F7F};

   int ph_w[10] = '{2047, 0, 1, 1024, 16, 8, 5, 7, 2, 4095};
   int ph_h[10] = '{4095, 0, 4095, 1, 16, 8, 7, 3, 2, 2};
   int ph_n[10] = '{40, 8, 10, 6, 272, 64, 35, 21, 8, 20};

   initial begin
      mip_word_type tw;
      pixel_type nopx;
      nopx = '0;
      for (int k = 0; k <= MAXL; k++) begin
         col_cnt[k] = 0;
         row_cnt[k] = 0;
         pend_px[k] = '0;
      end
      for (int i = 0; i < MAXW; i++) line_sum[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 20; i++) begin
         tw = '{4'd0, i[9:0], 12'd0, dir_px[i], 1'b1};
         send_word(dir_px[i], 1'b1, tw);
      end
      for (int p = 0; p < 10; p++) begin
         req_valid <= 1'b0;
         while (mip_q.size() != 0) @(posedge clock);
         @(posedge clock);
         write_reg(CSR_IMAGE_WIDTH, CSR_W'(ph_w[p]));
         write_reg(CSR_IMAGE_HEIGHT, CSR_W'(ph_h[p]));
         if (p == 5) write_reg(CSR_UNUSED, 12'd1);
         tw = '{4'd0, 10'd0, 12'd0, nopx, 1'b0};
         for (int i = 0; i < ph_n[p]; i++) send_word(rand_px(), 1'b0, tw);
      end
      req_valid <= 1'b0;
      while (mip_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fails == 0) $display("** mipmap_pyramid_box_downsampler_unit: PASSED **");
      else $display("** mipmap_pyramid_box_downsampler_unit: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout: %0d words still expected", mip_q.size());
      $display("** mipmap_pyramid_box_downsampler_unit: FAILED **");
      $finish;
   end
endmodule

>>> files.f
+incdir+src
src/mmbox_pkg.sv
src/mmbox_front.sv
src/mmbox_back.sv
src/mipmap_pyramid_box_downsampler_unit.sv
tb/sv/tb_top.sv
